FILE: rtl/vbw_pkg.sv
package vbw_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int LEN_W          = 6;
  localparam int ZERO_W         = 4;
  localparam int EG_W           = 16;

  localparam logic [7:0]  PREV_BYTE = 8'h03;
  localparam logic [15:0] UE_MAX    = 16'd65534;
  localparam logic [14:0] SE_MAX    = 15'd32767;

  localparam logic [2:0] ACT_RAW        = 3'd0;
  localparam logic [2:0] ACT_UE         = 3'd1;
  localparam logic [2:0] ACT_SE         = 3'd2;
  localparam logic [2:0] ACT_TRAIL      = 3'd3;
  localparam logic [2:0] ACT_ALIGN      = 3'd4;
  localparam logic [2:0] ACT_ALIGN_ZERO = 3'd5;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_BITS,
    KIND_TRAIL,
    KIND_ALIGN,
    KIND_PADZ
  } kind_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
    logic [5:0]  raw_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_prevention;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ZERO_W-1:0] zeros;
    logic [LEN_W-1:0]  len;
  } job_ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

endpackage

FILE: rtl/video_bitstream_writer_core.sv
// Bit-serial bitstream writer: each request (raw bits, ue, se, trailing bits, align,
// align zero) is encoded in two pipeline steps and then shifted out one bit per
// cycle, while the emit stage is ready, into the byte packer; finished bytes go
// through an emulation prevention stage that inserts 0x03 before a byte below 0x04
// that follows two zero bytes. One request at a time: a request occupies the block
// until all its bits (Exp-Golomb prefix, code bits and byte padding) are shifted
// out. Each inserted 0x03, and out_stall holding a finished byte, stall the
// shifter.
module video_bitstream_writer_core #(
  parameter int VALUE_BITS = vbw_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vbw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vbw_pkg::out_item_t  out_data
);

  localparam int SHW = (VALUE_BITS > vbw_pkg::EG_W) ? VALUE_BITS : vbw_pkg::EG_W;

  logic                enc_busy;
  logic                ser_busy;
  logic                in_take;
  logic                job_vld;
  logic                job_take;
  vbw_pkg::job_ctl_t   job_ctl;
  logic [SHW-1:0]      job_word;
  logic                emit_rdy;
  logic                byte_vld;
  vbw_pkg::byte_req_t  byte_req;

  assign in_stall = enc_busy || ser_busy;
  assign in_take  = in_valid && !in_stall;

  vbw_encode #(.VALUE_BITS(VALUE_BITS)) u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_data  (in_data),
    .busy     (enc_busy),
    .job_vld  (job_vld),
    .job_take (job_take),
    .job_ctl  (job_ctl),
    .job_word (job_word)
  );

  vbw_serial #(.VALUE_BITS(VALUE_BITS)) u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_vld  (job_vld),
    .job_ctl  (job_ctl),
    .job_word (job_word),
    .job_take (job_take),
    .busy     (ser_busy),
    .emit_rdy (emit_rdy),
    .byte_vld (byte_vld),
    .byte_req (byte_req)
  );

  vbw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .byte_req  (byte_req),
    .emit_rdy  (emit_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/vbw_encode.sv
module vbw_encode #(
  parameter int VALUE_BITS = vbw_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  vbw_pkg::in_item_t          in_data,
  output logic                       busy,
  output logic                       job_vld,
  input  logic                       job_take,
  output vbw_pkg::job_ctl_t          job_ctl,
  output logic [((VALUE_BITS > vbw_pkg::EG_W) ? VALUE_BITS : vbw_pkg::EG_W)-1:0]
                                     job_word
);

  localparam int SHW = (VALUE_BITS > vbw_pkg::EG_W) ? VALUE_BITS : vbw_pkg::EG_W;

  logic [VALUE_BITS-1:0]       val;
  logic [VALUE_BITS-1:0]       mag;
  logic                        neg;
  logic [14:0]                 se_m;
  logic [vbw_pkg::EG_W-1:0]    ue_code;
  logic [vbw_pkg::EG_W-1:0]    eg_val;

  vbw_pkg::kind_t              a_kind_nxt;
  logic [SHW-1:0]              a_word_nxt;
  logic [vbw_pkg::LEN_W-1:0]   a_len_nxt;
  logic                        a_eg_nxt;

  logic                        a_vld_r;
  vbw_pkg::kind_t              a_kind_r;
  logic [SHW-1:0]              a_word_r;
  logic [vbw_pkg::LEN_W-1:0]   a_len_r;
  logic                        a_eg_r;

  logic [vbw_pkg::ZERO_W-1:0]  lg;
  vbw_pkg::job_ctl_t           b_ctl_nxt;

  logic                        b_vld_r;
  vbw_pkg::job_ctl_t           b_ctl_r;
  logic [SHW-1:0]              b_word_r;
  logic                        a_move;

  // stage A: clamp and map the code number
  always_comb begin
    val     = in_data.value[VALUE_BITS-1:0];
    neg     = val[VALUE_BITS-1];
    mag     = neg ? (~val + 1'b1) : val;
    se_m    = (33'(mag) > 33'(vbw_pkg::SE_MAX)) ? vbw_pkg::SE_MAX : 15'(mag);
    ue_code = (33'(val) > 33'(vbw_pkg::UE_MAX)) ? vbw_pkg::UE_MAX : 16'(val);
    eg_val  = '0;
    a_kind_nxt = vbw_pkg::KIND_NONE;
    a_word_nxt = '0;
    a_len_nxt  = '0;
    a_eg_nxt   = 1'b0;
    case (in_data.action)
      vbw_pkg::ACT_RAW: begin
        a_kind_nxt = vbw_pkg::KIND_BITS;
        a_word_nxt[VALUE_BITS-1:0] = val;
        a_len_nxt = (in_data.raw_len > vbw_pkg::LEN_W'(VALUE_BITS)) ?
                    vbw_pkg::LEN_W'(VALUE_BITS) : in_data.raw_len;
      end
      vbw_pkg::ACT_UE: begin
        eg_val     = ue_code + 16'd1;
        a_kind_nxt = vbw_pkg::KIND_BITS;
        a_word_nxt = SHW'(eg_val);
        a_eg_nxt   = 1'b1;
      end
      vbw_pkg::ACT_SE: begin
        // positive maps to 2m-1, so the Exp-Golomb value is 2m; else 2m+1
        eg_val     = (neg || se_m == 15'd0) ? {se_m, 1'b1} : {se_m, 1'b0};
        a_kind_nxt = vbw_pkg::KIND_BITS;
        a_word_nxt = SHW'(eg_val);
        a_eg_nxt   = 1'b1;
      end
      vbw_pkg::ACT_TRAIL: begin
        a_kind_nxt = vbw_pkg::KIND_TRAIL;
        a_word_nxt = SHW'(1);
        a_len_nxt  = vbw_pkg::LEN_W'(1);
      end
      vbw_pkg::ACT_ALIGN: begin
        a_kind_nxt = vbw_pkg::KIND_ALIGN;
        a_word_nxt = SHW'(1);
        a_len_nxt  = vbw_pkg::LEN_W'(1);
      end
      vbw_pkg::ACT_ALIGN_ZERO: begin
        a_kind_nxt = vbw_pkg::KIND_PADZ;
      end
      default: begin
        a_kind_nxt = vbw_pkg::KIND_NONE;
      end
    endcase
  end

  // stage B: prefix length from the leading one
  always_comb begin
    lg = '0;
    for (int i = 0; i < vbw_pkg::EG_W; i++) begin
      if (a_word_r[i]) lg = vbw_pkg::ZERO_W'(i);
    end
    b_ctl_nxt.kind = a_kind_r;
    if (a_eg_r) begin
      b_ctl_nxt.zeros = lg;
      b_ctl_nxt.len   = vbw_pkg::LEN_W'(lg) + vbw_pkg::LEN_W'(1);
    end else begin
      b_ctl_nxt.zeros = '0;
      b_ctl_nxt.len   = a_len_r;
    end
  end

  assign a_move = a_vld_r && (!b_vld_r || job_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        a_vld_r <= 1'b1;
      end else if (a_move) begin
        a_vld_r <= 1'b0;
      end
      if (a_move) begin
        b_vld_r <= 1'b1;
      end else if (job_take) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_kind_r <= a_kind_nxt;
      a_word_r <= a_word_nxt;
      a_len_r  <= a_len_nxt;
      a_eg_r   <= a_eg_nxt;
    end
    if (a_move) begin
      b_ctl_r  <= b_ctl_nxt;
      b_word_r <= a_word_r;
    end
  end

  assign busy     = a_vld_r || b_vld_r;
  assign job_vld  = b_vld_r;
  assign job_ctl  = b_ctl_r;
  assign job_word = b_word_r;

endmodule

FILE: rtl/vbw_serial.sv
module vbw_serial #(
  parameter int VALUE_BITS = vbw_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_vld,
  input  vbw_pkg::job_ctl_t    job_ctl,
  input  logic [((VALUE_BITS > vbw_pkg::EG_W) ? VALUE_BITS : vbw_pkg::EG_W)-1:0] job_word,
  output logic                 job_take,
  output logic                 busy,
  input  logic                 emit_rdy,
  output logic                 byte_vld,
  output vbw_pkg::byte_req_t   byte_req
);

  localparam int SHW = (VALUE_BITS > vbw_pkg::EG_W) ? VALUE_BITS : vbw_pkg::EG_W;

  logic                        active_r;
  logic [SHW-1:0]              shreg_r;
  logic [vbw_pkg::ZERO_W-1:0]  pre_r;
  logic [vbw_pkg::LEN_W-1:0]   dat_r;
  logic [vbw_pkg::LEN_W-1:0]   rem_r;
  logic [7:0]                  part_r;
  logic [2:0]                  bcnt_r;

  logic [vbw_pkg::LEN_W-1:0]   sum;
  logic [2:0]                  padn;
  logic                        padded;
  logic                        skip;
  logic [vbw_pkg::LEN_W-1:0]   load_rem;
  logic                        step;
  logic                        cur_bit;

  always_comb begin
    sum      = vbw_pkg::LEN_W'(bcnt_r) + vbw_pkg::LEN_W'(job_ctl.zeros) + job_ctl.len;
    padn     = 3'd0 - sum[2:0];
    padded   = job_ctl.kind inside {vbw_pkg::KIND_TRAIL, vbw_pkg::KIND_ALIGN,
                                    vbw_pkg::KIND_PADZ};
    skip     = (job_ctl.kind == vbw_pkg::KIND_NONE) ||
               (job_ctl.kind == vbw_pkg::KIND_ALIGN && bcnt_r == 3'd0);
    load_rem = vbw_pkg::LEN_W'(job_ctl.zeros) + job_ctl.len +
               (padded ? vbw_pkg::LEN_W'(padn) : '0);
  end

  assign job_take = job_vld && !active_r;
  assign step     = active_r && emit_rdy;

  // prefix zeros, then code bits from the MSB, then pad zeros
  assign cur_bit = (pre_r != '0) ? 1'b0 : ((dat_r != '0) ? shreg_r[SHW-1] : 1'b0);

  assign byte_vld      = step && (bcnt_r == 3'd7);
  assign byte_req.data = {part_r[6:0], cur_bit};
  assign byte_req.last = (rem_r <= vbw_pkg::LEN_W'(8));
  assign busy          = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      bcnt_r   <= 3'd0;
      part_r   <= 8'd0;
    end else if (job_take) begin
      active_r <= !skip && (load_rem != '0);
      pre_r    <= job_ctl.zeros;
      dat_r    <= job_ctl.len;
      rem_r    <= load_rem;
      shreg_r  <= job_word << (vbw_pkg::LEN_W'(SHW) - job_ctl.len);
    end else if (step) begin
      part_r <= {part_r[6:0], cur_bit};
      bcnt_r <= bcnt_r + 3'd1;
      rem_r  <= rem_r - vbw_pkg::LEN_W'(1);
      if (rem_r == vbw_pkg::LEN_W'(1)) begin
        active_r <= 1'b0;
      end
      if (pre_r != '0) begin
        pre_r <= pre_r - vbw_pkg::ZERO_W'(1);
      end else if (dat_r != '0) begin
        dat_r   <= dat_r - vbw_pkg::LEN_W'(1);
        shreg_r <= {shreg_r[SHW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/vbw_emit.sv
module vbw_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  vbw_pkg::byte_req_t  byte_req,
  output logic                emit_rdy,
  output logic                out_valid,
  input  logic                out_stall,
  output vbw_pkg::out_item_t  out_data
);

  logic                out_vld_r;
  vbw_pkg::out_item_t  out_r;
  logic                pend_vld_r;
  vbw_pkg::byte_req_t  pend_r;
  logic [1:0]          zrun_r;
  logic                free;
  logic                need_prev;

  assign free      = !out_vld_r || !out_stall;
  assign emit_rdy  = free && !pend_vld_r;
  assign need_prev = (zrun_r == 2'd2) && (byte_req.data < 8'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      zrun_r     <= 2'd0;
    end else if (free) begin
      if (pend_vld_r) begin
        out_vld_r           <= 1'b1;
        out_r.out_byte      <= pend_r.data;
        out_r.is_prevention <= 1'b0;
        out_r.last          <= pend_r.last;
        pend_vld_r          <= 1'b0;
      end else if (byte_vld) begin
        out_vld_r <= 1'b1;
        if (need_prev) begin
          // insert 0x03 first and hold the byte in pend_r until the output is free
          out_r.out_byte      <= vbw_pkg::PREV_BYTE;
          out_r.is_prevention <= 1'b1;
          out_r.last          <= 1'b0;
          pend_r              <= byte_req;
          pend_vld_r          <= 1'b1;
          zrun_r              <= (byte_req.data == 8'd0) ? 2'd1 : 2'd0;
        end else begin
          out_r.out_byte      <= byte_req.data;
          out_r.is_prevention <= 1'b0;
          out_r.last          <= byte_req.last;
          zrun_r              <= (byte_req.data == 8'd0) ? (zrun_r + 2'd1) : 2'd0;
        end
      end else begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/vbw_checker.sv
module vbw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input vbw_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_prev_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_prevention |->
      out_data.out_byte == vbw_pkg::PREV_BYTE && !out_data.last)
    else $error("malformed prevention byte");

  a_prev_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.is_prevention |=>
      out_valid && !out_data.is_prevention && out_data.out_byte < 8'd4)
    else $error("prevention byte not followed by a low byte");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

endmodule

bind video_bitstream_writer_core vbw_checker u_vbw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
